// ===== rtl/qsfm_pkg.sv =====
// Shared types, constants and gain table for the quadrotor state feedback mixer.
package qsfm_pkg;

    localparam int NUM_STATES   = 12;
    localparam int NUM_ROTORS   = 4;
    localparam int DEF_FRAC     = 16;
    localparam int GAIN_W       = 24;
    localparam int ERR_W        = 32;
    localparam int POS_W        = 24;
    localparam int ANG_W        = 20;
    localparam int RATE_W       = 22;
    localparam int CMD_W        = 8;
    localparam int MIXC_W       = 22;
    localparam int SPD_W        = 20;
    localparam int SLOPE_W      = 16;
    localparam int OFS_W        = 24;
    localparam int U_W          = 32;
    localparam int CMD_MAX      = 200;

    localparam logic [2:0] REG_HOVER  = 3'd0;
    localparam logic [2:0] REG_RPMIX  = 3'd1;
    localparam logic [2:0] REG_THMIX  = 3'd2;
    localparam logic [2:0] REG_YWMIX  = 3'd3;
    localparam logic [2:0] REG_MAXSQ  = 3'd4;
    localparam logic [2:0] REG_MINSQ  = 3'd5;
    localparam logic [2:0] REG_SLOPE  = 3'd6;
    localparam logic [2:0] REG_OFFSET = 3'd7;

    localparam logic [MIXC_W-1:0]  RST_HOVER  = 22'd459524;
    localparam logic [MIXC_W-1:0]  RST_RPMIX  = 22'd394259;
    localparam logic [MIXC_W-1:0]  RST_THMIX  = 22'd33512;
    localparam logic [MIXC_W-1:0]  RST_YWMIX  = 22'd2032520;
    localparam logic [SPD_W-1:0]   RST_MAXSQ  = 20'd607720;
    localparam logic [SPD_W-1:0]   RST_MINSQ  = 20'd12703;
    localparam logic [SLOPE_W-1:0] RST_SLOPE  = 16'd15626;
    localparam logic [OFS_W-1:0]   RST_OFFSET = 24'd1695589;

    localparam logic signed [GAIN_W-1:0] GAIN_INIT [NUM_STATES*NUM_ROTORS] = '{
        24'sd0, 24'sd87597, 24'sd0, 24'sd0, 24'sd0, 24'sd128697,
        24'sd0, 24'sd48260, 24'sd0, 24'sd9875, 24'sd0, 24'sd0,
        -24'sd86472, 24'sd0, 24'sd0, 24'sd0, 24'sd126715, 24'sd0,
        -24'sd47580, 24'sd0, 24'sd0, 24'sd0, 24'sd9660, 24'sd0,
        24'sd0, 24'sd0, 24'sd0, 24'sd108100, 24'sd0, 24'sd0,
        24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd12423,
        24'sd0, 24'sd0, -24'sd302981, 24'sd0, 24'sd0, 24'sd0,
        24'sd0, 24'sd0, -24'sd168743, 24'sd0, 24'sd0, 24'sd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MIX,
        ST_ROOT,
        ST_CMD,
        ST_OUT
    } qsfm_state_t;

    typedef struct packed {
        logic       mac_clr;
        logic       mac_en;
        logic [3:0] col;
        logic       mix_clr;
        logic       mix_en;
        logic [1:0] term;
        logic       root_ld;
        logic       root_en;
        logic       cmd_en;
    } qsfm_ctl_t;

    typedef struct packed {
        logic [MIXC_W-1:0]  hover;
        logic [MIXC_W-1:0]  rp_mix;
        logic [MIXC_W-1:0]  th_mix;
        logic [MIXC_W-1:0]  yw_mix;
        logic [SPD_W-1:0]   max_sq;
        logic [SPD_W-1:0]   min_sq;
        logic [SLOPE_W-1:0] slope;
        logic [OFS_W-1:0]   offset;
    } qsfm_cfg_t;

    function automatic logic signed [GAIN_W-1:0] gain_at(input logic [5:0] idx);
        gain_at = GAIN_INIT[idx];
    endfunction

endpackage

// ===== rtl/qsfm_if.sv =====
// Valid/ready channel interfaces for sensor samples and motor commands.
interface qsfm_in_if
    import qsfm_pkg::*;
;
    logic valid;
    logic ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [POS_W-1:0]  goal_z;
    logic signed [ANG_W-1:0]  yaw_angle;
    logic signed [ANG_W-1:0]  pitch_angle;
    logic signed [ANG_W-1:0]  roll_angle;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;

    modport source (output valid, pos_x, pos_y, pos_z, goal_x, goal_y, goal_z,
                    yaw_angle, pitch_angle, roll_angle, rate_x, rate_y, rate_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, goal_x, goal_y, goal_z,
                  yaw_angle, pitch_angle, roll_angle, rate_x, rate_y, rate_z,
                  output ready);
endinterface

interface qsfm_out_if
    import qsfm_pkg::*;
;
    logic valid;
    logic ready;
    logic [CMD_W-1:0] motor_0;
    logic [CMD_W-1:0] motor_1;
    logic [CMD_W-1:0] motor_2;
    logic [CMD_W-1:0] motor_3;

    modport source (output valid, motor_0, motor_1, motor_2, motor_3, input ready);
    modport sink (input valid, motor_0, motor_1, motor_2, motor_3, output ready);
endinterface

// ===== rtl/qsfm_gain_lane.sv =====
// One gain row: serial multiply-accumulate of the error state, negated and saturated.
module qsfm_gain_lane
    import qsfm_pkg::*;
#(
    parameter int ROW       = 0,
    parameter int FRAC_BITS = DEF_FRAC
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  qsfm_ctl_t               ctl,
    input  logic signed [ERR_W-1:0] err,
    input  logic [MIXC_W-1:0]       hover,
    output logic signed [U_W-1:0]   u
);
    localparam int PROD_W = GAIN_W + ERR_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int SH_W   = ACC_W - FRAC_BITS;
    localparam int DIF_W  = SH_W + 1;
    localparam logic [5:0] ROW_BASE = 6'(ROW * NUM_STATES);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     en_d_reg;
    logic signed [SH_W-1:0]   acc_sh;
    logic signed [DIF_W-1:0]  dif;
    logic signed [DIF_W-1:0]  u_hi;
    logic signed [DIF_W-1:0]  u_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_d_reg <= 1'b0;
        end
        else
        begin
            en_d_reg <= ctl.mac_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac_en)
        begin
            prod_reg <= gain_at(ROW_BASE + {2'b00, ctl.col}) * err;
        end
        if (ctl.mac_clr)
        begin
            acc_reg <= '0;
        end
        else if (en_d_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc_sh = SH_W'(acc_reg >>> FRAC_BITS);
    assign dif    = (ROW == NUM_ROTORS - 1 ? $signed({{(DIF_W-MIXC_W){1'b0}}, hover})
                                           : DIF_W'(0)) - DIF_W'(acc_sh);
    assign u_hi   = DIF_W'(signed'({1'b0, {(U_W-1){1'b1}}}));
    assign u_lo   = DIF_W'(signed'({1'b1, {(U_W-1){1'b0}}}));

    always_comb
    begin
        priority if (dif > u_hi)
            u = {1'b0, {(U_W-1){1'b1}}};
        else if (dif < u_lo)
            u = {1'b1, {(U_W-1){1'b0}}};
        else
            u = U_W'(dif);
    end
endmodule

// ===== rtl/qsfm_rotor_lane.sv =====
// One rotor: mixing, squared speed clamp, bit-serial root and command mapping.
module qsfm_rotor_lane
    import qsfm_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int FRAC_BITS = DEF_FRAC
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  qsfm_ctl_t             ctl,
    input  qsfm_cfg_t             cfg,
    input  logic signed [U_W-1:0] u0,
    input  logic signed [U_W-1:0] u1,
    input  logic signed [U_W-1:0] u2,
    input  logic signed [U_W-1:0] u3,
    output logic [CMD_W-1:0]      cmd
);
    localparam int MP_W  = MIXC_W + 1 + U_W;
    localparam int WA_W  = MP_W + 3;
    localparam int SQ_W  = SPD_W + FRAC_BITS;
    localparam int RW    = (SQ_W + FRAC_BITS + 1) / 2;
    localparam int RADW  = 2 * RW;
    localparam int CP_W  = SLOPE_W + RW;
    localparam int C_W   = CP_W + 2;
    localparam bit T0_NEG = (IDX == 1) || (IDX == 2);
    localparam bit T1_NEG = (IDX == 0) || (IDX == 2);
    localparam bit T0_U0  = (IDX == 1) || (IDX == 3);

    logic signed [MP_W-1:0] mprod_reg;
    logic                   mneg_reg;
    logic                   men_d_reg;
    logic signed [WA_W-1:0] wacc_reg;
    logic [RADW-1:0]        rad_reg;
    logic [RW+1:0]          rem_reg;
    logic [RW-1:0]          root_reg;
    logic [CP_W-1:0]        cprod_reg;

    logic [MIXC_W-1:0]      coef;
    logic signed [U_W-1:0]  usel;
    logic                   neg;
    logic signed [WA_W-1:0] maxq;
    logic signed [WA_W-1:0] minq;
    logic [SQ_W-1:0]        sq;
    logic [RW+3:0]          cat;
    logic [RW+3:0]          trial;
    logic signed [C_W-1:0]  cval;

    always_comb
    begin
        unique case (ctl.term)
            2'd0:
            begin
                coef = cfg.rp_mix;
                usel = T0_U0 ? u0 : u1;
                neg  = T0_NEG;
            end
            2'd1:
            begin
                coef = cfg.yw_mix;
                usel = u2;
                neg  = T1_NEG;
            end
            default:
            begin
                coef = cfg.th_mix;
                usel = u3;
                neg  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            men_d_reg <= 1'b0;
        end
        else
        begin
            men_d_reg <= ctl.mix_en;
        end
    end

    assign maxq = $signed(WA_W'({cfg.max_sq, {FRAC_BITS{1'b0}}}));
    assign minq = $signed(WA_W'({cfg.min_sq, {FRAC_BITS{1'b0}}}));

    always_comb
    begin
        priority if (wacc_reg > maxq)
            sq = SQ_W'(maxq);
        else if (wacc_reg < minq)
            sq = SQ_W'(minq);
        else
            sq = SQ_W'(wacc_reg);
    end

    assign cat   = {rem_reg, rad_reg[RADW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (ctl.mix_en)
        begin
            mprod_reg <= $signed({1'b0, coef}) * usel;
            mneg_reg  <= neg;
        end
        if (ctl.mix_clr)
        begin
            wacc_reg <= '0;
        end
        else if (men_d_reg)
        begin
            wacc_reg <= mneg_reg ? wacc_reg - WA_W'(mprod_reg) : wacc_reg + WA_W'(mprod_reg);
        end
        if (ctl.root_ld)
        begin
            rad_reg  <= RADW'({sq, {FRAC_BITS{1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctl.root_en)
        begin
            rad_reg <= {rad_reg[RADW-3:0], 2'b00};
            if (cat >= trial)
            begin
                rem_reg  <= (RW+2)'(cat - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= (RW+2)'(cat);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        if (ctl.cmd_en)
        begin
            cprod_reg <= cfg.slope * root_reg;
        end
    end

    assign cval = $signed(C_W'(cprod_reg >> FRAC_BITS)) - $signed(C_W'(cfg.offset));

    always_comb
    begin
        priority if (cval < $signed(C_W'(1) <<< FRAC_BITS))
            cmd = CMD_W'(1);
        else if (cval > $signed(C_W'(CMD_MAX) <<< FRAC_BITS))
            cmd = CMD_W'(CMD_MAX);
        else
            cmd = CMD_W'(cval >>> FRAC_BITS);
    end
endmodule

// ===== rtl/quadrotor_state_feedback_mixer_unit.sv =====
// Top level: configuration registers, velocity estimator, sequencer and motor command output.
//
// Quadrotor state feedback controller with rotor mixer.
// sample channel: one item per control tick carries measured and goal position,
// attitude and body rates. motors channel: one item of four motor commands.
// APB port: eight registers at byte addresses 4*i; the user writes them only while
// idle, as the block itself does not enforce it. Each item passes through serial
// multiply-accumulate (one gain column per cycle, four row lanes side by side),
// mixing (three products per rotor lane), a bit-serial square root of RW result
// bits where RW = (20 + 2*FRAC_BITS + 1)/2, command scaling and the loading of the
// output register. The square root loop is the longest step. A sample is taken
// only while idle, so each item is finished before the next one is accepted.
// A new item is taken while the output register still holds a result; if the
// receiver stalls, the next result waits in the final step until the register
// frees. Reset restores register defaults, clears the position memory, the
// velocity estimate and the started flag, and empties the output register.
module quadrotor_state_feedback_mixer_unit
    import qsfm_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC
)
(
    input  logic        clk,
    input  logic        rst_n,
    qsfm_in_if.sink     sample,
    qsfm_out_if.source  motors,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int RW    = (SPD_W + 2 * FRAC_BITS + 1) / 2;
    localparam int CNT_W = $clog2(RW + 16);
    localparam int VD_W  = POS_W + 1;

    qsfm_cfg_t                cfg_reg;
    qsfm_state_t              state_reg;
    qsfm_state_t              state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic signed [POS_W-1:0]  prev_reg [3];
    logic signed [ERR_W-1:0]  vel_reg [3];
    logic                     started_reg;
    logic signed [ERR_W-1:0]  err_reg [NUM_STATES];
    logic                     out_valid_reg;
    logic [CMD_W-1:0]         m0_reg, m1_reg, m2_reg, m3_reg;

    qsfm_ctl_t                ctl;
    logic                     accept;
    logic                     moved;
    logic                     slot_free;
    logic signed [POS_W-1:0]  pos [3];
    logic signed [POS_W-1:0]  goal [3];
    logic signed [VD_W-1:0]   vdiff [3];
    logic signed [ERR_W-1:0]  vnew [3];
    logic signed [ERR_W-1:0]  err_sel;
    logic signed [U_W-1:0]    u [NUM_ROTORS];
    logic [CMD_W-1:0]         cmd [NUM_ROTORS];
    logic                     wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hover  <= RST_HOVER;
            cfg_reg.rp_mix <= RST_RPMIX;
            cfg_reg.th_mix <= RST_THMIX;
            cfg_reg.yw_mix <= RST_YWMIX;
            cfg_reg.max_sq <= RST_MAXSQ;
            cfg_reg.min_sq <= RST_MINSQ;
            cfg_reg.slope  <= RST_SLOPE;
            cfg_reg.offset <= RST_OFFSET;
        end
        else if (wr)
        begin
            unique case (paddr[4:2])
                REG_HOVER:  cfg_reg.hover  <= pwdata[MIXC_W-1:0];
                REG_RPMIX:  cfg_reg.rp_mix <= pwdata[MIXC_W-1:0];
                REG_THMIX:  cfg_reg.th_mix <= pwdata[MIXC_W-1:0];
                REG_YWMIX:  cfg_reg.yw_mix <= pwdata[MIXC_W-1:0];
                REG_MAXSQ:  cfg_reg.max_sq <= pwdata[SPD_W-1:0];
                REG_MINSQ:  cfg_reg.min_sq <= pwdata[SPD_W-1:0];
                REG_SLOPE:  cfg_reg.slope  <= pwdata[SLOPE_W-1:0];
                default:    cfg_reg.offset <= pwdata[OFS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_HOVER:  prdata = 32'(cfg_reg.hover);
            REG_RPMIX:  prdata = 32'(cfg_reg.rp_mix);
            REG_THMIX:  prdata = 32'(cfg_reg.th_mix);
            REG_YWMIX:  prdata = 32'(cfg_reg.yw_mix);
            REG_MAXSQ:  prdata = 32'(cfg_reg.max_sq);
            REG_MINSQ:  prdata = 32'(cfg_reg.min_sq);
            REG_SLOPE:  prdata = 32'(cfg_reg.slope);
            default:    prdata = 32'(cfg_reg.offset);
        endcase
    end

    assign pos[0]  = sample.pos_x;
    assign pos[1]  = sample.pos_y;
    assign pos[2]  = sample.pos_z;
    assign goal[0] = sample.goal_x;
    assign goal[1] = sample.goal_y;
    assign goal[2] = sample.goal_z;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign slot_free    = !out_valid_reg || motors.ready;
    assign moved        = (pos[0] != prev_reg[0]) || (pos[1] != prev_reg[1]) ||
                          (pos[2] != prev_reg[2]);

    // velocity = 50 * delta, as 32 + 16 + 2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vdiff[i] = VD_W'(pos[i]) - VD_W'(prev_reg[i]);
            vnew[i]  = (ERR_W'(vdiff[i]) <<< 5) + (ERR_W'(vdiff[i]) <<< 4) +
                       (ERR_W'(vdiff[i]) <<< 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= '0;
                vel_reg[i]  <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= pos[i];
            end
            if (moved)
            begin
                started_reg <= 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    vel_reg[i] <= started_reg ? vnew[i] : '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                err_reg[i]     <= ERR_W'(pos[i]) - ERR_W'(goal[i]);
                err_reg[6 + i] <= moved ? (started_reg ? vnew[i] : '0) : vel_reg[i];
            end
            err_reg[3]  <= ERR_W'(sample.yaw_angle);
            err_reg[4]  <= ERR_W'(sample.pitch_angle);
            err_reg[5]  <= ERR_W'(sample.roll_angle);
            err_reg[9]  <= ERR_W'(sample.rate_x);
            err_reg[10] <= ERR_W'(sample.rate_y);
            err_reg[11] <= ERR_W'(sample.rate_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (cnt_reg == CNT_W'(NUM_STATES))
                begin
                    state_next = ST_MIX;
                    cnt_next   = '0;
                end
            end
            ST_MIX:
            begin
                if (cnt_reg == CNT_W'(3))
                begin
                    state_next = ST_ROOT;
                    cnt_next   = '0;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == CNT_W'(RW))
                begin
                    state_next = ST_CMD;
                    cnt_next   = '0;
                end
            end
            ST_CMD:
            begin
                state_next = ST_OUT;
                cnt_next   = '0;
            end
            default:
            begin
                cnt_next = '0;
                if (slot_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.col     = cnt_reg[3:0];
        ctl.term    = cnt_reg[1:0];
        ctl.mac_clr = accept;
        unique case (state_reg)
            ST_IDLE: ;
            ST_MAC:
            begin
                ctl.mac_en  = (cnt_reg < CNT_W'(NUM_STATES));
                ctl.mix_clr = (cnt_reg == CNT_W'(NUM_STATES));
            end
            ST_MIX:
            begin
                ctl.mix_en = (cnt_reg < CNT_W'(3));
            end
            ST_ROOT:
            begin
                ctl.root_ld = (cnt_reg == '0);
                ctl.root_en = (cnt_reg != '0);
            end
            ST_CMD:
            begin
                ctl.cmd_en = 1'b1;
            end
            default: ;
        endcase
    end

    assign err_sel = err_reg[cnt_reg[3:0] < 4'(NUM_STATES) ? cnt_reg[3:0] : 4'd0];

    for (genvar r = 0; r < NUM_ROTORS; r++)
    begin : g_lane
        qsfm_gain_lane #(
            .ROW       (r),
            .FRAC_BITS (FRAC_BITS)
        ) u_gain (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .err   (err_sel),
            .hover (cfg_reg.hover),
            .u     (u[r])
        );

        qsfm_rotor_lane #(
            .IDX       (r),
            .FRAC_BITS (FRAC_BITS)
        ) u_rotor (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .cfg   (cfg_reg),
            .u0    (u[0]),
            .u1    (u[1]),
            .u2    (u[2]),
            .u3    (u[3]),
            .cmd   (cmd[r])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (motors.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // motor slots: rotor 0, 2, 3, 1
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && slot_free)
        begin
            m0_reg <= cmd[0];
            m1_reg <= cmd[2];
            m2_reg <= cmd[3];
            m3_reg <= cmd[1];
        end
    end

    assign motors.valid   = out_valid_reg;
    assign motors.motor_0 = m0_reg;
    assign motors.motor_1 = m1_reg;
    assign motors.motor_2 = m2_reg;
    assign motors.motor_3 = m3_reg;
endmodule

// ===== rtl/qsfm_checker.sv =====
// Port-level assertions for the quadrotor state feedback mixer, bound to the top level.
module qsfm_checker
    import qsfm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CMD_W-1:0] motor_0,
    input logic [CMD_W-1:0] motor_1,
    input logic             pready
);
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while busy");

    a_no_result_soon: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motor_0) && $stable(motor_1))
        else $error("stalled result changed");

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> motor_0 >= 8'd1 && motor_0 <= 8'(CMD_MAX) &&
                      motor_1 >= 8'd1 && motor_1 <= 8'(CMD_MAX) && pready)
        else $error("motor command out of range");
endmodule

bind quadrotor_state_feedback_mixer_unit qsfm_checker u_qsfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (motors.valid),
    .out_ready (motors.ready),
    .motor_0   (motors.motor_0),
    .motor_1   (motors.motor_1),
    .pready    (pready)
);
